/* sv/laqs_pkg.sv */
package laqs_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CAP_EFF_W   = IDX_W + 1;
  localparam int CFG_W       = 5;
  localparam int CMP_W       = (CAP_EFF_W > CFG_W) ? CAP_EFF_W : CFG_W;
  localparam int OUT_IDX_W   = 4;
  localparam int VALUE_W     = 32;

  // Command queue between front and back
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_AW       = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_ENQ    = 3'd0,
    ACT_DEQ    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_LIST   = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    act_e                       act;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  value;
    logic [OUT_IDX_W-1:0]       index;
    logic                       last;
  } result_t;

  // Clamp the configured capacity into 1..DEPTH
  function automatic logic [CAP_EFF_W-1:0] cap_eff(input logic [CFG_W-1:0] c);
    logic [CMP_W-1:0] cw;
    logic [CMP_W-1:0] res;
    cw = CMP_W'(c);
    if (c == '0) begin
      res = CMP_W'(1);
    end else if (cw > CMP_W'(DEPTH)) begin
      res = CMP_W'(DEPTH);
    end else begin
      res = cw;
    end
    return res[CAP_EFF_W-1:0];
  endfunction

  // Slot index as reported on the result: low bits, zero-extended
  function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] x);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, x};
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

/* sv/laqs_front.sv */
module laqs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [31:0]          s_tdata_i,   // [31:0] value
  input  logic [2:0]           s_tuser_i,   // [2:0] action
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output laqs_pkg::cmd_t       cmd_o
);

  laqs_pkg::cmd_t                   q_q [laqs_pkg::CQ_DEPTH];
  logic [laqs_pkg::CQ_AW-1:0]       wptr_q, rptr_q;
  logic [laqs_pkg::CQ_CNT_W-1:0]    count_q;
  logic                             known_act;
  logic                             push, pop;
  laqs_pkg::cmd_t                   in_cmd;

  // Classify: unknown actions are accepted and dropped
  always_comb begin
    case (s_tuser_i)
      laqs_pkg::ACT_ENQ,
      laqs_pkg::ACT_DEQ,
      laqs_pkg::ACT_PEEK,
      laqs_pkg::ACT_SEARCH,
      laqs_pkg::ACT_LIST: known_act = 1'b1;
      default:            known_act = 1'b0;
    endcase
  end

  assign in_cmd.act   = laqs_pkg::act_e'(s_tuser_i);
  assign in_cmd.value = s_tdata_i;

  assign s_tready_o  = (count_q != laqs_pkg::CQ_CNT_W'(laqs_pkg::CQ_DEPTH));
  assign push        = s_tvalid_i && s_tready_o && known_act;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_q[rptr_q];

  // Command storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= in_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == laqs_pkg::CQ_AW'(laqs_pkg::CQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == laqs_pkg::CQ_AW'(laqs_pkg::CQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= laqs_pkg::CQ_CNT_W'(laqs_pkg::CQ_DEPTH))
    else $error("command queue overfilled");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("push lost");

  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && !known_act && !pop) |=> $stable(count_q))
    else $error("unknown action queued");

endmodule

/* sv/laqs_back.sv */
module laqs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  laqs_pkg::cmd_t                     cmd_i,
  input  logic [laqs_pkg::CAP_EFF_W-1:0]     cap_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [39:0]                        m_tdata_o,  // [31:0] item_value, [35:32] item_index
  output logic [1:0]                         m_tuser_o,  // [1:0] status
  output logic                               m_tlast_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam int IW = laqs_pkg::IDX_W;

  logic signed [laqs_pkg::VALUE_W-1:0] entries [laqs_pkg::DEPTH];

  logic [1:0]                          state_q, state_d;
  logic [IW-1:0]                       front_q, front_d, rear_q, rear_d;
  logic                                empty_q, empty_d;
  logic [IW-1:0]                       walk_q, walk_d;
  logic signed [laqs_pkg::VALUE_W-1:0] key_q, key_d;
  logic                                list_q, list_d;
  logic                                pend_v_q, pend_v_d;
  logic signed [laqs_pkg::VALUE_W-1:0] pend_val_q, pend_val_d;
  logic [IW-1:0]                       pend_idx_q, pend_idx_d;
  logic                                out_v_q, out_v_d;
  laqs_pkg::result_t                   out_q, out_d;
  logic signed [laqs_pkg::VALUE_W-1:0] rd_q;

  logic                                out_free;
  logic [IW-1:0]                       rd_addr;
  logic                                wr_en;
  logic [IW-1:0]                       wr_idx;
  logic                                emit;
  laqs_pkg::result_t                   res;
  logic                                match, at_end;

  // Read address for the next cycle: the walk slot, else the front slot
  assign out_free    = !out_v_q || m_tready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign rd_addr     = (state_d == S_WALK) ? walk_d : front_d;
  assign match       = list_q || (rd_q == key_q);
  assign at_end      = (walk_q == rear_q);

  // Command execution and result walk
  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    rear_d     = rear_q;
    empty_d    = empty_q;
    walk_d     = walk_q;
    key_d      = key_q;
    list_d     = list_q;
    pend_v_d   = pend_v_q;
    pend_val_d = pend_val_q;
    pend_idx_d = pend_idx_q;
    wr_en      = 1'b0;
    wr_idx     = '0;
    emit       = 1'b0;
    res        = '{status: laqs_pkg::ST_OK, value: '0, index: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          if (cmd_i.act == laqs_pkg::ACT_ENQ) begin
            emit = 1'b1;
            if (!empty_q && (({1'b0, rear_q} + 1'b1) >= cap_i)) begin
              res.status = laqs_pkg::ST_FULL;
            end else begin
              wr_idx    = empty_q ? '0 : rear_q + 1'b1;
              wr_en     = 1'b1;
              rear_d    = wr_idx;
              front_d   = empty_q ? '0 : front_q;
              empty_d   = 1'b0;
              res.value = cmd_i.value;
              res.index = laqs_pkg::out_index(wr_idx);
            end
          end else if (empty_q) begin
            emit       = 1'b1;
            res.status = laqs_pkg::ST_EMPTY;
          end else begin
            case (cmd_i.act)
              laqs_pkg::ACT_DEQ: begin
                emit      = 1'b1;
                res.value = rd_q;
                res.index = laqs_pkg::out_index(front_q);
                if (front_q == rear_q) begin
                  front_d = '0;
                  rear_d  = '0;
                  empty_d = 1'b1;
                end else begin
                  front_d = front_q + 1'b1;
                end
              end
              laqs_pkg::ACT_PEEK: begin
                emit      = 1'b1;
                res.value = rd_q;
                res.index = laqs_pkg::out_index(front_q);
              end
              laqs_pkg::ACT_SEARCH,
              laqs_pkg::ACT_LIST: begin
                state_d  = S_WALK;
                walk_d   = front_q;
                key_d    = cmd_i.value;
                list_d   = (cmd_i.act == laqs_pkg::ACT_LIST);
                pend_v_d = 1'b0;
              end
              default: begin
                emit = 1'b0;
              end
            endcase
          end
        end
      end

      // One slot per cycle, held while a second match meets a busy output; a match
      // is held back until the next one shows whether it is the final result
      S_WALK: begin
        if (!(match && pend_v_q && !out_free)) begin
          if (match) begin
            if (pend_v_q) begin
              emit      = 1'b1;
              res.value = pend_val_q;
              res.index = laqs_pkg::out_index(pend_idx_q);
              res.last  = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_val_d = rd_q;
            pend_idx_d = walk_q;
          end
          if (at_end) begin
            state_d = S_FLUSH;
          end else begin
            walk_d = walk_q + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (pend_v_q) begin
            res.value = pend_val_q;
            res.index = laqs_pkg::out_index(pend_idx_q);
          end else begin
            res.status = laqs_pkg::ST_NOT_FOUND;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (emit) begin
      out_v_d = 1'b1;
      out_d   = res;
    end else if (m_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  // Slot storage, registered read with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries[wr_idx] <= cmd_i.value;
    end
    if (wr_en && (wr_idx == rd_addr)) begin
      rd_q <= cmd_i.value;
    end else begin
      rd_q <= entries[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_q     <= walk_d;
    key_q      <= key_d;
    list_q     <= list_d;
    pend_val_q <= pend_val_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      rear_q   <= '0;
      empty_q  <= 1'b1;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      rear_q   <= rear_d;
      empty_q  <= empty_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tuser_o  = out_q.status;
  assign m_tlast_o  = out_q.last;
  assign m_tdata_o  = {4'b0, out_q.index, out_q.value};

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (front_q == '0) && (rear_q == '0))
    else $error("ends not home while empty");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> front_q <= rear_q)
    else $error("front passed rear");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walk_q >= front_q) && (walk_q <= rear_q))
    else $error("walk outside stored slots");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && out_free) |=> (state_q == S_IDLE) && out_v_q && out_q.last)
    else $error("walk did not close with a final item");

endmodule

/* sv/linear_array_queue_with_search.sv */
// Linear array queue with search. Items arrive as an action in s_tuser_i
// (0 enqueue, 1 dequeue, 2 peek, 3 search, 4 list; other codes are taken and
// dropped) and a value in s_tdata_i. Each action gives one or more result
// items on the m_ side, the last one flagged by m_tlast_o; status rides in
// m_tuser_o. A two-entry command queue lets the input side keep taking items
// while the execution engine works. Search and list walk the stored slots
// front to rear through the single slot read port, one slot per cycle while
// the output side can take each result item. Freed slots are reused only
// once the queue has drained. Write the capacity (cfg_wdata_i, 1..16; 0 acts
// as 1) only while the block is idle; reset leaves it at 16. No clearing pass.
module linear_array_queue_with_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [2:0]  s_tuser_i,   // [2:0] action
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [31:0] item_value, [35:32] item_index, rest zero
  output logic [1:0]  m_tuser_o,   // [1:0] status
  output logic        m_tlast_o    // last
);

  logic [laqs_pkg::CFG_W-1:0]     cap_q;
  logic [laqs_pkg::CAP_EFF_W-1:0] cap_eff_q;
  logic                           cmd_valid, cmd_ready;
  laqs_pkg::cmd_t                 cmd;

  // Capacity register, clamped copy kept registered for the full check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= laqs_pkg::CFG_W'(16);
      cap_eff_q <= laqs_pkg::cap_eff(laqs_pkg::CFG_W'(16));
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cap_eff_q <= laqs_pkg::cap_eff(cap_q);
    end
  end

  laqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  laqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cap_i       (cap_eff_q),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

/* tb/sv/tb_linear_array_queue_with_search.sv */
`timescale 1ns / 100ps

module tb_linear_array_queue_with_search;

  localparam int unsigned SETTLE_CYCLES = 24;     // idle cycles before a capacity write
  localparam int unsigned DRAIN_CYCLES  = 40;     // quiet time after the last result
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_MAX    = 10;

  // action codes the block takes and drops
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  // pending stimulus: either an item or a capacity write
  typedef struct {
    bit          is_cfg;
    bit          hold;      // start the long receiver hold-off when this item goes out
    logic [2:0]  act;
    logic [31:0] val;
    logic [4:0]  cap;
  } stim_t;

  typedef struct {
    laqs_pkg::status_e status;
    logic [31:0]       value;
    logic [3:0]        index;
    logic              last;
  } qresult_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i   = '0;   // [31:0] value
  logic [2:0]  s_tuser_i   = '0;   // [2:0] action
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [39:0] m_tdata_o;          // [31:0] item_value, [35:32] item_index, rest zero
  logic [1:0]  m_tuser_o;          // [1:0] status
  logic        m_tlast_o;

  linear_array_queue_with_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stim_t       op_backlog[$];
  qresult_t    pending_results[$];

  // queue shadow
  logic [31:0] slots [laqs_pkg::DEPTH];
  int unsigned q_front = 0;
  int unsigned q_rear  = 0;
  bit          q_empty = 1'b1;
  logic [4:0]  cap_reg = 5'd16;

  // bookkeeping
  int unsigned items_in      = 0;
  int unsigned cfg_writes    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned status_hits [4];
  int unsigned stall_cycles  = 0;
  int unsigned cycle_count   = 0;

  // driver state
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned settle_left = SETTLE_CYCLES;
  bit          drv_valid;
  bit          drv_we;
  bit          drv_go;
  stim_t       drv_next;
  logic        press_go = 1'b0;

  // receiver state
  int unsigned rx_left   = 0;
  int unsigned rx_mode   = 0;
  int unsigned hold_left = 0;
  bit          rx_ready;
  qresult_t    want;

  function automatic int unsigned cap_limit(input logic [4:0] c);
    if (c == 5'd0) return 1;
    if (c > laqs_pkg::DEPTH) return laqs_pkg::DEPTH;
    return {27'd0, c};
  endfunction

  function automatic void add_expected(input laqs_pkg::status_e st, input logic [31:0] v,
                                       input int unsigned idx, input logic lst);
    qresult_t r;
    r.status = st;
    r.value  = v;
    r.index  = 4'(idx);
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // Expected results of one accepted item; updates the shadow queue
  function automatic void predict_queue_op(input logic [2:0] act, input logic [31:0] val);
    int unsigned lim;
    int unsigned k;
    int unsigned hits;
    lim  = cap_limit(cap_reg);
    hits = 0;
    case (act)
      laqs_pkg::ACT_ENQ: begin
        if (!q_empty && q_rear + 1 >= lim) begin
          add_expected(laqs_pkg::ST_FULL, '0, 0, 1'b1);
        end else begin
          if (q_empty) begin
            q_front = 0;
            q_rear  = 0;
            q_empty = 1'b0;
          end else begin
            q_rear++;
          end
          slots[q_rear] = val;
          add_expected(laqs_pkg::ST_OK, val, q_rear, 1'b1);
        end
      end
      laqs_pkg::ACT_DEQ, laqs_pkg::ACT_PEEK, laqs_pkg::ACT_SEARCH, laqs_pkg::ACT_LIST: begin
        if (q_empty) begin
          add_expected(laqs_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else if (act == laqs_pkg::ACT_DEQ) begin
          add_expected(laqs_pkg::ST_OK, slots[q_front], q_front, 1'b1);
          slots[q_front] = '0;
          if (q_front == q_rear) begin
            q_front = 0;
            q_rear  = 0;
            q_empty = 1'b1;
          end else begin
            q_front++;
          end
        end else if (act == laqs_pkg::ACT_PEEK) begin
          add_expected(laqs_pkg::ST_OK, slots[q_front], q_front, 1'b1);
        end else begin
          // search and list walk front to rear
          for (k = q_front; k <= q_rear; k++) begin
            if (act == laqs_pkg::ACT_LIST || slots[k] == val) begin
              add_expected(laqs_pkg::ST_OK, slots[k], k, 1'b0);
              hits++;
            end
          end
          if (hits == 0) add_expected(laqs_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
          else pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
      default: ;  // unused codes: no result, no change
    endcase
  endfunction

  task automatic add_op(input logic [2:0] act, input logic [31:0] val, input bit hold = 1'b0);
    stim_t s;
    s.is_cfg = 1'b0;
    s.hold   = hold;
    s.act    = act;
    s.val    = val;
    s.cap    = '0;
    op_backlog.push_back(s);
  endtask

  task automatic add_cap(input logic [4:0] c);
    stim_t s;
    s.is_cfg = 1'b1;
    s.hold   = 1'b0;
    s.act    = laqs_pkg::ACT_ENQ;
    s.val    = '0;
    s.cap    = c;
    op_backlog.push_back(s);
  endtask

  // A small pool so searches hit, plus extremes and fully random words
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4, 5, 6: return 32'($urandom_range(1, 4));
      default: return $urandom();
    endcase
  endfunction

  // Alternating fill and drain runs so the queue reaches full and empties again
  task automatic add_random_run(input int unsigned n_items);
    int unsigned k;
    int unsigned r;
    int unsigned run_left;
    bit          filling;
    logic [2:0]  act;
    run_left = 0;
    filling  = 1'b0;
    for (k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(6, 16);
        filling  = !filling;
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (filling) begin
        if (r < 60)      act = laqs_pkg::ACT_ENQ;
        else if (r < 70) act = laqs_pkg::ACT_DEQ;
        else if (r < 78) act = laqs_pkg::ACT_PEEK;
        else if (r < 88) act = laqs_pkg::ACT_SEARCH;
        else if (r < 96) act = laqs_pkg::ACT_LIST;
        else             act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end else begin
        if (r < 15)      act = laqs_pkg::ACT_ENQ;
        else if (r < 65) act = laqs_pkg::ACT_DEQ;
        else if (r < 73) act = laqs_pkg::ACT_PEEK;
        else if (r < 85) act = laqs_pkg::ACT_SEARCH;
        else if (r < 96) act = laqs_pkg::ACT_LIST;
        else             act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      add_op(act, pick_value());
    end
  endtask

  // Driver: items from the backlog in random bursts; capacity writes only when idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
      press_go   <= 1'b0;
    end else begin
      drv_valid = s_tvalid_i && !s_tready_o;
      drv_we    = 1'b0;
      drv_go    = 1'b0;
      if (s_tvalid_i && s_tready_o) begin
        predict_queue_op(s_tuser_i, s_tdata_i);
        items_in++;
      end
      if (!drv_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (op_backlog.size() != 0) begin
          if (op_backlog[0].is_cfg) begin
            // wait for the block to drain, then for the settle count to run out
            if (pending_results.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left != 0) begin
              settle_left--;
            end else begin
              drv_next = op_backlog.pop_front();
              drv_we   = 1'b1;
              cap_reg  = drv_next.cap;
              cfg_wdata_i <= drv_next.cap;
              cfg_writes++;
              settle_left = SETTLE_CYCLES;
            end
          end else begin
            drv_next  = op_backlog.pop_front();
            drv_valid = 1'b1;
            drv_go    = drv_next.hold;
            s_tdata_i <= drv_next.val;
            s_tuser_i <= drv_next.act;
            if (burst_left != 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 11);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end
      end
      s_tvalid_i <= drv_valid;
      cfg_we_i   <= drv_we;
      press_go   <= drv_go;
    end
  end

  // Long hold-off of the receiver, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (press_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result item against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (s_tvalid_i && !s_tready_o) stall_cycles++;
      if (m_tvalid_o && m_tready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected result %0d: status %0d value %h index %0d last %0b",
                     results_seen, m_tuser_o, m_tdata_o[31:0], m_tdata_o[35:32], m_tlast_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          status_hits[want.status]++;
          if (m_tuser_o !== want.status || m_tdata_o[31:0] !== want.value ||
              m_tdata_o[35:32] !== want.index || m_tdata_o[39:36] !== 4'd0 ||
              m_tlast_o !== want.last) begin
            if (mismatches < REPORT_MAX) begin
              $write("mismatch on result %0d: exp status %0d value %h index %0d last %0b,",
                     results_seen, want.status, want.value, want.index, want.last);
              $display(" got status %0d value %h index %0d last %0b pad %h",
                       m_tuser_o, m_tdata_o[31:0], m_tdata_o[35:32], m_tlast_o,
                       m_tdata_o[39:36]);
            end
            mismatches++;
          end
        end
      end
      // stall pattern: always ready, coin flip, or mostly stalled
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       rx_ready = 1'b1;
        1:       rx_ready = 1'($urandom_range(0, 1));
        default: rx_ready = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left != 0) rx_ready = 1'b0;
      m_tready_i <= rx_ready;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_results.size());
      $display("tb_linear_array_queue_with_search NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned k;

    // empty queue on every action but enqueue, unused codes ignored
    add_op(laqs_pkg::ACT_PEEK, 32'h0);
    add_op(laqs_pkg::ACT_DEQ, 32'h0);
    add_op(laqs_pkg::ACT_SEARCH, 32'h0);
    add_op(laqs_pkg::ACT_LIST, 32'h0);
    add_op(ACT_UNUSED_LO, 32'hFFFF_FFFF);
    add_op(ACT_UNUSED_HI, 32'h1234_5678);
    // value extremes, a duplicate key, search hits and a miss
    add_op(laqs_pkg::ACT_ENQ, 32'h7FFF_FFFF);
    add_op(laqs_pkg::ACT_ENQ, 32'h8000_0000);
    add_op(laqs_pkg::ACT_ENQ, 32'h0000_0000);
    add_op(laqs_pkg::ACT_ENQ, 32'hFFFF_FFFF);
    add_op(laqs_pkg::ACT_ENQ, 32'h7FFF_FFFF);
    add_op(laqs_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
    add_op(laqs_pkg::ACT_SEARCH, 32'd12345);
    add_op(laqs_pkg::ACT_LIST, 32'h0);
    add_op(laqs_pkg::ACT_PEEK, 32'h0);
    add_op(laqs_pkg::ACT_DEQ, 32'h0);
    add_op(laqs_pkg::ACT_DEQ, 32'h0);
    add_op(laqs_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
    // capacity lowered below the rear: full until drained
    add_cap(5'd4);
    add_op(laqs_pkg::ACT_ENQ, 32'h0000_0001);
    for (k = 0; k < 3; k++) add_op(laqs_pkg::ACT_DEQ, 32'h0);
    for (k = 0; k < 5; k++) add_op(laqs_pkg::ACT_ENQ, 32'h0000_0100 + k);

    // random phases over several capacities, extremes included
    add_cap(5'd1);
    add_random_run(12);
    add_cap(5'd0);
    add_random_run(6);
    add_cap(5'd31);
    add_random_run(14);
    add_cap(5'd2);
    add_random_run(8);

    // full depth up to the top slot, then a long receiver hold-off
    add_cap(5'd16);
    for (k = 0; k < laqs_pkg::DEPTH; k++) add_op(laqs_pkg::ACT_DEQ, 32'h0);
    for (k = 0; k < laqs_pkg::DEPTH; k++) add_op(laqs_pkg::ACT_ENQ, pick_value());
    add_op(laqs_pkg::ACT_ENQ, 32'h5555_5555);
    add_op(laqs_pkg::ACT_LIST, 32'h0, 1'b1);
    for (k = 0; k < 4; k++) add_op(laqs_pkg::ACT_LIST, 32'h0);
    add_op(laqs_pkg::ACT_SEARCH, 32'h0000_0002);
    add_op(laqs_pkg::ACT_SEARCH, 32'h7FFF_FFFF);

    add_cap(5'(17));
    add_random_run(6);
    add_cap(5'($urandom_range(3, 15)));
    add_random_run(14);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || s_tvalid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d items over %0d capacity settings, %0d result items checked",
             items_in, cfg_writes, results_seen);
    $display("status ok %0d, full %0d, empty %0d, not found %0d; input stalled %0d cycles",
             status_hits[laqs_pkg::ST_OK], status_hits[laqs_pkg::ST_FULL],
             status_hits[laqs_pkg::ST_EMPTY], status_hits[laqs_pkg::ST_NOT_FOUND],
             stall_cycles);
    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_linear_array_queue_with_search OK");
    end else begin
      $display("tb_linear_array_queue_with_search NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/laqs_pkg.sv
sv/laqs_front.sv
sv/laqs_back.sv
sv/linear_array_queue_with_search.sv
tb/sv/tb_linear_array_queue_with_search.sv
